[hdl/sblm_pkg.sv]
// Shared types, constants and the bar edge table builder for the spectrum bar level meter.
// Used by every module in this folder but sblm_queue; it depends on nothing else.
package sblm_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int HALF_BINS_DEF = 1024;
    localparam int NUM_BARS_DEF  = 32;

    // Fixed field widths.
    localparam int MAG_W      = 32;
    localparam int LEVEL_W    = 13;
    localparam int FLOOR_W    = 7;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd1;

    // Configuration reset values.
    localparam logic [LEVEL_W-1:0] DECAY_RESET = 13'd3482;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 7'd80;

    // Level arithmetic constants.
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 13'd4096;
    localparam logic [MAG_W-1:0]   THRESH_RAW  = 32'd16;
    localparam logic signed [19:0] DB_PER_LOG2 = 20'sd394566;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Bar edge table, sized for the largest bar count.
    localparam int EDGE_W      = 13;
    localparam int EDGE_TAB_N  = 65;
    localparam int EDGE_IDX_W  = 7;
    localparam longint unsigned Q30_ONE  = 64'd1 << 30;
    localparam longint unsigned EDGE_DEN = 64'd1023 << 30;

    typedef logic [EDGE_W-1:0] edge_tab_t [EDGE_TAB_N];

    // Control bits that travel with each bin word through the queue.
    typedef struct packed {
        logic wr;
        logic last;
    } bin_ctl_t;

    // Builds the log-spaced bin edges at elaboration time. The mantissa of
    // 2^(r/N) is found by bisection on its N-th power in Q30, truncating.
    function automatic edge_tab_t build_edges(input int half_bins, input int bar_total);
        edge_tab_t       tab;
        int              q;
        int              r;
        int              n;
        int              ex;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned y;
        longint unsigned v;
        bit              ok;
        for (int i = 0; i < EDGE_TAB_N; i++) begin
            tab[i] = '0;
            if (i <= bar_total) begin
                q = 0;
                r = 10 * i;
                while (r >= bar_total) begin
                    r = r - bar_total;
                    q = q + 1;
                end
                lo = Q30_ONE;
                hi = Q30_ONE << 1;
                while (hi - lo > 64'd1) begin
                    mid = lo + ((hi - lo) >> 1);
                    y   = Q30_ONE;
                    ex  = 0;
                    for (n = 0; n < bar_total; n++) begin
                        y = (y * mid) >> 30;
                        if (y >= (Q30_ONE << 1)) begin
                            y  = y >> 1;
                            ex = ex + 1;
                        end
                    end
                    ok = (ex < r) || ((ex == r) && (y == Q30_ONE));
                    if (ok) begin
                        lo = mid;
                    end else begin
                        hi = mid;
                    end
                end
                v = (((lo << q) - Q30_ONE) * 64'(half_bins)) / EDGE_DEN;
                if (v > 64'(half_bins - 1)) begin
                    v = 64'(half_bins - 1);
                end
                tab[i] = EDGE_W'(v);
            end
        end
        return tab;
    endfunction

endpackage

[hdl/sblm_front.sv]
// Front end of the spectrum bar level meter: takes bin words and assigns store addresses.
// Depends on sblm_pkg for the word control struct and field widths.
module sblm_front #(
    parameter int HALF_BINS = sblm_pkg::HALF_BINS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sblm_pkg::MAG_W-1:0]      s_magnitude,
    input  logic                            s_last_bin,
    output logic                            q_valid,
    input  logic                            q_ready,
    output sblm_pkg::bin_ctl_t              q_ctl,
    output logic [$clog2(HALF_BINS)-1:0]    q_addr,
    output logic [sblm_pkg::MAG_W-1:0]      q_mag
);

    localparam int ADDR_W = $clog2(HALF_BINS);
    localparam int FILL_W = $clog2(HALF_BINS + 1);

    logic                       f_valid_reg, f_valid_next;
    sblm_pkg::bin_ctl_t         f_ctl_reg, f_ctl_next;
    logic [ADDR_W-1:0]          f_addr_reg, f_addr_next;
    logic [sblm_pkg::MAG_W-1:0] f_mag_reg, f_mag_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic                       accept;
    logic                       room;

    // The holding register frees up whenever its word moves into the queue.
    assign s_ready = !f_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign room    = (fill_reg < FILL_W'(HALF_BINS));

    // Classify the word: store it while the frame fits, drop it otherwise.
    always_comb begin
        f_valid_next = f_valid_reg;
        f_ctl_next   = f_ctl_reg;
        f_addr_next  = f_addr_reg;
        f_mag_next   = f_mag_reg;
        fill_next    = fill_reg;
        if (f_valid_reg && q_ready) begin
            f_valid_next = 1'b0;
        end
        if (accept) begin
            f_valid_next    = 1'b1;
            f_ctl_next.wr   = room;
            f_ctl_next.last = s_last_bin;
            f_addr_next     = fill_reg[ADDR_W-1:0];
            f_mag_next      = s_magnitude;
            if (s_last_bin) begin
                fill_next = '0;
            end else if (room) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            fill_reg    <= '0;
        end else begin
            f_valid_reg <= f_valid_next;
            fill_reg    <= fill_next;
        end
        f_ctl_reg  <= f_ctl_next;
        f_addr_reg <= f_addr_next;
        f_mag_reg  <= f_mag_next;
    end

    assign q_valid = f_valid_reg;
    assign q_ctl   = f_ctl_reg;
    assign q_addr  = f_addr_reg;
    assign q_mag   = f_mag_reg;

endmodule

[hdl/sblm_queue.sv]
// Small first-in first-out queue that decouples the front and back of the bar meter.
// Depends on nothing but its parameters.
module sblm_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg < CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    // A push without a pop grows the fill count by exactly one.
    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

[hdl/sblm_log.sv]
// Iterative level unit: peak magnitude to a Q12 bar level through log2, dB and a divider.
// Depends on sblm_pkg for widths and the level constants.
module sblm_log (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [sblm_pkg::MAG_W-1:0]     peak,
    input  logic [sblm_pkg::FLOOR_W-1:0]   floor_db,
    output logic                           done,
    output logic [sblm_pkg::LEVEL_W-1:0]   level
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_NORM = 3'd1;
    localparam logic [2:0] L_SQ   = 3'd2;
    localparam logic [2:0] L_MUL  = 3'd3;
    localparam logic [2:0] L_NUM  = 3'd4;
    localparam logic [2:0] L_DIV  = 3'd5;
    localparam logic [2:0] L_DONE = 3'd6;

    localparam logic [4:0] SQ_LAST  = 5'd15;
    localparam logic [4:0] DIV_LAST = 5'd19;

    logic [2:0]                     state_reg, state_next;
    logic [31:0]                    x_reg, x_next;
    logic [4:0]                     p_reg, p_next;
    logic [30:0]                    mant_reg, mant_next;
    logic [15:0]                    frac_reg, frac_next;
    logic [4:0]                     cnt_reg, cnt_next;
    logic signed [41:0]             prod_reg, prod_next;
    logic [19:0]                    dvd_reg, dvd_next;
    logic [6:0]                     rem_reg, rem_next;
    logic [19:0]                    quo_reg, quo_next;
    logic [6:0]                     div_reg, div_next;
    logic [sblm_pkg::LEVEL_W-1:0]   level_reg, level_next;

    logic [61:0]                    sq;
    logic [31:0]                    sq_hi;
    logic [5:0]                     p_off;
    logic signed [21:0]             l16;
    logic signed [41:0]             prod_c;
    logic signed [41:0]             num_c;
    logic [7:0]                     rem_sh;
    logic                           ge;
    logic [19:0]                    quo_c;

    // Datapath pieces: squaring step, dB product, numerator and divider step.
    always_comb begin
        sq     = mant_reg * mant_reg;
        sq_hi  = sq[61:30];
        p_off  = {1'b0, p_reg} - 6'd24;
        l16    = $signed({p_off, frac_reg});
        prod_c = l16 * sblm_pkg::DB_PER_LOG2;
        num_c  = prod_reg + $signed({3'b000, div_reg, 32'h0000_0000});
        rem_sh = {rem_reg, dvd_reg[19]};
        ge     = (rem_sh >= {1'b0, div_reg});
        quo_c  = {quo_reg[18:0], ge};
    end

    // Sequencer: normalize, square sixteen times, scale, divide by the floor.
    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        level_next = level_reg;
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    div_next = (floor_db == '0) ? 7'd1 : floor_db;
                    if (peak <= sblm_pkg::THRESH_RAW) begin
                        level_next = '0;
                        state_next = L_DONE;
                    end else begin
                        x_next     = peak;
                        p_next     = 5'd31;
                        state_next = L_NORM;
                    end
                end
            end
            L_NORM: begin
                if (x_reg[31]) begin
                    mant_next  = x_reg[31:1];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = L_SQ;
                end else begin
                    x_next = {x_reg[30:0], 1'b0};
                    p_next = p_reg - 5'd1;
                end
            end
            L_SQ: begin
                mant_next = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
                frac_next = {frac_reg[14:0], sq_hi[31]};
                if (cnt_reg == SQ_LAST) begin
                    state_next = L_MUL;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            L_MUL: begin
                prod_next  = prod_c;
                state_next = L_NUM;
            end
            L_NUM: begin
                if (num_c <= 42'sd0) begin
                    level_next = '0;
                    state_next = L_DONE;
                end else begin
                    dvd_next   = num_c[39:20];
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = L_DIV;
                end
            end
            L_DIV: begin
                rem_next = ge ? 7'(rem_sh - {1'b0, div_reg}) : rem_sh[6:0];
                quo_next = quo_c;
                dvd_next = {dvd_reg[18:0], 1'b0};
                if (cnt_reg == DIV_LAST) begin
                    level_next = (quo_c > 20'(sblm_pkg::LEVEL_FULL)) ?
                                 sblm_pkg::LEVEL_FULL : quo_c[sblm_pkg::LEVEL_W-1:0];
                    state_next = L_DONE;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            L_DONE: begin
                state_next = L_IDLE;
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg     <= x_next;
        p_reg     <= p_next;
        mant_reg  <= mant_next;
        frac_reg  <= frac_next;
        cnt_reg   <= cnt_next;
        prod_reg  <= prod_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
        level_reg <= level_next;
    end

    assign done  = (state_reg == L_DONE);
    assign level = level_reg;

endmodule

[hdl/sblm_back.sv]
// Back end of the bar meter: bin store, bar walk, peak search, decay and result register.
// Depends on sblm_pkg and instantiates sblm_log.
module sblm_back #(
    parameter int HALF_BINS = sblm_pkg::HALF_BINS_DEF,
    parameter int NUM_BARS  = sblm_pkg::NUM_BARS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  sblm_pkg::bin_ctl_t              q_ctl,
    input  logic [$clog2(HALF_BINS)-1:0]    q_addr,
    input  logic [sblm_pkg::MAG_W-1:0]      q_mag,
    input  logic [sblm_pkg::LEVEL_W-1:0]    decay_factor,
    input  logic [sblm_pkg::FLOOR_W-1:0]    floor_db,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sblm_pkg::IDX_W-1:0]      m_bar_index,
    output logic [sblm_pkg::LEVEL_W-1:0]    m_bar_level,
    output logic                            m_last_bar
);

    localparam int ADDR_W = $clog2(HALF_BINS);
    localparam int BAR_W  = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int LVL_W  = sblm_pkg::LEVEL_W;
    localparam int EIW    = sblm_pkg::EDGE_IDX_W;
    localparam logic [BAR_W-1:0] LAST_BAR = BAR_W'(NUM_BARS - 1);
    localparam sblm_pkg::edge_tab_t EDGES = sblm_pkg::build_edges(HALF_BINS, NUM_BARS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BAR    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_LSTART = 3'd4;
    localparam logic [2:0] S_LWAIT  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [sblm_pkg::MAG_W-1:0] bin_mem [HALF_BINS];
    logic [LVL_W-1:0]           bar_mem [NUM_BARS];

    logic [2:0]                 state_reg, state_next;
    logic [BAR_W-1:0]           bar_reg, bar_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic [ADDR_W-1:0]          hi_reg, hi_next;
    logic [sblm_pkg::MAG_W-1:0] peak_reg, peak_next;
    logic                       rd_pend_reg;
    logic [sblm_pkg::MAG_W-1:0] bin_q_reg;
    logic [LVL_W-1:0]           bar_q_reg;
    logic                       bar_hit_reg;
    logic [NUM_BARS-1:0]        bar_vld_reg;
    logic [LVL_W-1:0]           dec_reg, dec_next;
    logic [LVL_W-1:0]           lvl_reg, lvl_next;
    logic                       m_valid_reg, m_valid_next;
    logic [BAR_W-1:0]           m_bar_reg, m_bar_next;
    logic [LVL_W-1:0]           m_level_reg, m_level_next;
    logic                       m_last_reg, m_last_next;

    logic [sblm_pkg::EDGE_W-1:0] lo_edge;
    logic [sblm_pkg::EDGE_W-1:0] hi_edge;
    logic [ADDR_W-1:0]           lo_addr;
    logic [ADDR_W-1:0]           hi_addr;
    logic                        bin_we;
    logic                        bin_re;
    logic                        bar_we;
    logic                        bar_re;
    logic                        log_start;
    logic                        log_done;
    logic [LVL_W-1:0]            log_level;
    logic [LVL_W-1:0]            old_level;
    logic [2*LVL_W-1:0]          dec_prod;
    logic [LVL_W:0]              dec_shift;
    logic [LVL_W-1:0]            lvl_new;
    logic                        out_free;

    // Range of the current bar from the edge table; an empty range keeps its low edge.
    always_comb begin
        lo_edge = EDGES[EIW'(bar_reg)];
        hi_edge = EDGES[EIW'(bar_reg) + EIW'(1)];
        lo_addr = ADDR_W'(lo_edge);
        hi_addr = (hi_edge < lo_edge) ? lo_addr : ADDR_W'(hi_edge);
    end

    // Decay of the stored level and the larger of new and decayed.
    always_comb begin
        old_level = bar_hit_reg ? bar_q_reg : '0;
        dec_prod  = old_level * decay_factor;
        dec_shift = dec_prod[2*LVL_W-1:12];
        lvl_new   = (log_level < dec_reg) ? dec_reg : log_level;
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign bin_we    = q_valid && q_ready && q_ctl.wr;
    assign bin_re    = (state_reg == S_SCAN);
    assign bar_re    = (state_reg == S_BAR);
    assign bar_we    = (state_reg == S_LWAIT) && log_done;
    assign log_start = (state_reg == S_LSTART);
    assign out_free  = !m_valid_reg || m_ready;

    // Walk sequencer: one bar after another, result held until taken.
    always_comb begin
        state_next   = state_reg;
        bar_next     = bar_reg;
        addr_next    = addr_reg;
        hi_next      = hi_reg;
        peak_next    = peak_reg;
        dec_next     = dec_reg;
        lvl_next     = lvl_reg;
        m_valid_next = m_valid_reg;
        m_bar_next   = m_bar_reg;
        m_level_next = m_level_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (rd_pend_reg && (bin_q_reg > peak_reg)) begin
            peak_next = bin_q_reg;
        end
        case (state_reg)
            S_IDLE: begin
                if (q_valid && q_ctl.last) begin
                    bar_next   = '0;
                    state_next = S_BAR;
                end
            end
            S_BAR: begin
                addr_next  = lo_addr;
                hi_next    = hi_addr;
                peak_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (addr_reg == hi_reg) begin
                    state_next = S_DRAIN;
                end else begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                dec_next   = (dec_shift > {1'b0, sblm_pkg::LEVEL_FULL}) ?
                             sblm_pkg::LEVEL_FULL : dec_shift[LVL_W-1:0];
                state_next = S_LSTART;
            end
            S_LSTART: begin
                state_next = S_LWAIT;
            end
            S_LWAIT: begin
                if (log_done) begin
                    lvl_next   = lvl_new;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_bar_next   = bar_reg;
                    m_level_next = lvl_reg;
                    m_last_next  = (bar_reg == LAST_BAR);
                    if (bar_reg == LAST_BAR) begin
                        state_next = S_IDLE;
                    end else begin
                        bar_next   = bar_reg + BAR_W'(1);
                        state_next = S_BAR;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            bar_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= bin_re;
            m_valid_reg <= m_valid_next;
            if (bar_we) begin
                bar_vld_reg[bar_reg] <= 1'b1;
            end
        end
        bar_reg     <= bar_next;
        addr_reg    <= addr_next;
        hi_reg      <= hi_next;
        peak_reg    <= peak_next;
        dec_reg     <= dec_next;
        lvl_reg     <= lvl_next;
        m_bar_reg   <= m_bar_next;
        m_level_reg <= m_level_next;
        m_last_reg  <= m_last_next;
    end

    // Bin store: one write port from the queue, one registered read for the walk.
    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[q_addr] <= q_mag;
        end
        if (bin_re) begin
            bin_q_reg <= bin_mem[addr_reg];
        end
    end

    // Bar level store; an entry never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (bar_we) begin
            bar_mem[bar_reg] <= lvl_new;
        end
        if (bar_re) begin
            bar_q_reg   <= bar_mem[bar_reg];
            bar_hit_reg <= bar_vld_reg[bar_reg];
        end
    end

    sblm_log u_log (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (log_start),
        .peak     (peak_reg),
        .floor_db (floor_db),
        .done     (log_done),
        .level    (log_level)
    );

    assign m_valid     = m_valid_reg;
    assign m_bar_index = sblm_pkg::IDX_W'(m_bar_reg);
    assign m_bar_level = m_level_reg;
    assign m_last_bar  = m_last_reg;

    // A reported level never passes full scale.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_level_reg <= sblm_pkg::LEVEL_FULL))
        else $error("bar level above full scale");

    // The scan address never runs past the end of the bar range.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (addr_reg <= hi_reg))
        else $error("scan address past bar range");

endmodule

[hdl/spectrum_bar_level_meter_core.sv]
// Top level of the spectrum bar level meter: configuration registers, front, queue and back.
// Depends on sblm_pkg, sblm_front, sblm_queue and sblm_back.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   bins     | s_valid s_ready s_magnitude s_last_bin  | in
//   bars     | m_valid m_ready m_bar_index m_bar_level | out
//            | m_last_bar                              |
//   config   | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// Bin words are taken one per cycle while the command queue has room; the back end
// stores one bin per cycle while it is not walking the bars. A last-bin word starts
// the bar walk, which reads the bin store once per bin in each bar range and runs the
// level unit per bar (normalizing shifts, 16 squarings and the 20-step divider; a peak
// at or below the threshold skips them). Input stalls once the queue fills during the
// walk; a stalled result holds the walk. Reset clears control state and bar levels at
// once; there is no clearing pass.
module spectrum_bar_level_meter_core #(
    parameter int HALF_BINS = sblm_pkg::HALF_BINS_DEF,
    parameter int NUM_BARS  = sblm_pkg::NUM_BARS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sblm_pkg::MAG_W-1:0]         s_magnitude,
    input  logic                               s_last_bin,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sblm_pkg::IDX_W-1:0]         m_bar_index,
    output logic [sblm_pkg::LEVEL_W-1:0]       m_bar_level,
    output logic                               m_last_bar,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sblm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sblm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(HALF_BINS);
    localparam int CMD_W  = 2 + ADDR_W + sblm_pkg::MAG_W;

    logic [sblm_pkg::LEVEL_W-1:0] decay_reg;
    logic [sblm_pkg::FLOOR_W-1:0] floor_reg;

    logic                       f_valid;
    logic                       f_ready;
    sblm_pkg::bin_ctl_t         f_ctl;
    logic [ADDR_W-1:0]          f_addr;
    logic [sblm_pkg::MAG_W-1:0] f_mag;
    logic [CMD_W-1:0]           f_cmd;

    logic                       b_valid;
    logic                       b_ready;
    logic [CMD_W-1:0]           b_cmd;
    sblm_pkg::bin_ctl_t         b_ctl;
    logic [ADDR_W-1:0]          b_addr;
    logic [sblm_pkg::MAG_W-1:0] b_mag;

    // Configuration registers; writes to unused indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= sblm_pkg::DECAY_RESET;
            floor_reg <= sblm_pkg::FLOOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sblm_pkg::REG_DECAY: decay_reg <= cfg_data[sblm_pkg::LEVEL_W-1:0];
                sblm_pkg::REG_FLOOR: floor_reg <= cfg_data[sblm_pkg::FLOOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sblm_front #(
        .HALF_BINS (HALF_BINS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_magnitude (s_magnitude),
        .s_last_bin  (s_last_bin),
        .q_valid     (f_valid),
        .q_ready     (f_ready),
        .q_ctl       (f_ctl),
        .q_addr      (f_addr),
        .q_mag       (f_mag)
    );

    // Commands are flattened for the queue and split again on the far side.
    assign f_cmd = {f_ctl, f_addr, f_mag};
    assign {b_ctl, b_addr, b_mag} = b_cmd;

    sblm_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (sblm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_cmd)
    );

    sblm_back #(
        .HALF_BINS (HALF_BINS),
        .NUM_BARS  (NUM_BARS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_ctl        (b_ctl),
        .q_addr       (b_addr),
        .q_mag        (b_mag),
        .decay_factor (decay_reg),
        .floor_db     (floor_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bar_index  (m_bar_index),
        .m_bar_level  (m_bar_level),
        .m_last_bar   (m_last_bar)
    );

endmodule

[bench/testbench.sv]
// Self-checking bench for spectrum_bar_level_meter_core: drives bin frames, predicts the bar levels.
// Depends on sblm_pkg for field widths, register indexes and reset values, and on the core itself.
module testbench;

    localparam int MAG_W      = sblm_pkg::MAG_W;
    localparam int IDX_W      = sblm_pkg::IDX_W;
    localparam int LEVEL_W    = sblm_pkg::LEVEL_W;
    localparam int FLOOR_W    = sblm_pkg::FLOOR_W;
    localparam int CFG_IDX_W  = sblm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sblm_pkg::CFG_DATA_W;

    localparam int BIN_COUNT     = sblm_pkg::HALF_BINS_DEF;
    localparam int BAR_COUNT     = sblm_pkg::NUM_BARS_DEF;
    localparam int CYCLE_LIMIT   = 30000000;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 400;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [MAG_W-1:0] mag;
        logic             last;
    } bin_word_t;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } bar_word_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [MAG_W-1:0]      s_magnitude = '0;
    logic                  s_last_bin  = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [IDX_W-1:0]      m_bar_index;
    logic [LEVEL_W-1:0]    m_bar_level;
    logic                  m_last_bar;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // Bins waiting to be offered and bar results waiting to come out.
    bin_word_t bin_queue[$];
    bar_word_t bar_expect[$];

    // Shadow of the block state and its registers.
    logic [MAG_W-1:0]   bin_mem [BIN_COUNT];
    int unsigned        fill_cnt = 0;
    logic [LEVEL_W-1:0] bar_lvl [BAR_COUNT];
    logic [LEVEL_W-1:0] decay_q12  = sblm_pkg::DECAY_RESET;
    logic [FLOOR_W-1:0] floor_span = sblm_pkg::FLOOR_RESET;
    int unsigned        edge_tab [BAR_COUNT+1];

    idle_mode_t  idle_mode   = IDLE_NONE;
    int unsigned hold_left   = 0;
    bit          hold_used   = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    spectrum_bar_level_meter_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_magnitude (s_magnitude),
        .s_last_bin  (s_last_bin),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bar_index (m_bar_index),
        .m_bar_level (m_bar_level),
        .m_last_bar  (m_last_bar),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Bin edge of range boundary i. The mantissa of 2^(r/N) is found by bisection on its
    // N-th power in Q30, and the scaled value is clamped to the last bin.
    function automatic int unsigned bar_edge(int i);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned y;
        longint unsigned v;
        int              q;
        int              r;
        int              carry;
        q  = (10 * i) / BAR_COUNT;
        r  = (10 * i) % BAR_COUNT;
        lo = ONE_Q30;
        hi = ONE_Q30 << 1;
        while (hi - lo > 1) begin
            mid   = lo + (hi - lo) / 2;
            y     = ONE_Q30;
            carry = 0;
            for (int n = 0; n < BAR_COUNT; n++) begin
                y = (y * mid) >> 30;
                if (y >= (ONE_Q30 << 1)) begin
                    y = y >> 1;
                    carry++;
                end
            end
            if (carry < r || (carry == r && y == ONE_Q30)) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        v = (((lo << q) - ONE_Q30) * 64'(BIN_COUNT)) / (64'd1023 << 30);
        if (v > 64'(BIN_COUNT - 1)) begin
            v = 64'(BIN_COUNT - 1);
        end
        return int'(v);
    endfunction

    // Peak magnitude to Q12 level: log2 by repeated squaring, scaled to dB, then mapped
    // from the floor span onto 0..full scale.
    function automatic logic [LEVEL_W-1:0] level_from_peak(logic [MAG_W-1:0] peak);
        int              lead;
        int unsigned     frac;
        longint unsigned x;
        longint          l16;
        longint          span;
        longint          num;
        if (peak <= sblm_pkg::THRESH_RAW) begin
            return '0;
        end
        lead = 31;
        while (!peak[lead]) begin
            lead--;
        end
        if (lead >= 30) begin
            x = 64'(peak) >> (lead - 30);
        end else begin
            x = 64'(peak) << (30 - lead);
        end
        frac = 0;
        for (int k = 0; k < 16; k++) begin
            x    = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (ONE_Q30 << 1)) begin
                x    = x >> 1;
                frac = frac | 1;
            end
        end
        l16  = longint'(lead - 24) * 65536 + longint'(frac);
        span = (floor_span == 0) ? 64'sd1 : longint'(floor_span);
        num  = l16 * longint'(sblm_pkg::DB_PER_LOG2) + (span << 32);
        if (num <= 0) begin
            return '0;
        end
        num = num / (span << 20);
        return (num > 4096) ? sblm_pkg::LEVEL_FULL : LEVEL_W'(num);
    endfunction

    // Stores one accepted bin; on the last bin of a frame, walks the bars and queues
    // the level each one should report.
    task automatic predict_bars(bin_word_t word);
        int unsigned        lo;
        int unsigned        hi;
        logic [MAG_W-1:0]   peak;
        logic [LEVEL_W-1:0] lvl;
        longint unsigned    decayed;
        bar_word_t          res;
        if (fill_cnt < BIN_COUNT) begin
            bin_mem[fill_cnt] = word.mag;
            fill_cnt++;
        end
        if (!word.last) begin
            return;
        end
        for (int b = 0; b < BAR_COUNT; b++) begin
            lo   = edge_tab[b];
            hi   = edge_tab[b+1];
            peak = '0;
            if (hi < lo) begin
                hi = lo;
            end
            for (int unsigned k = lo; k <= hi && k < BIN_COUNT; k++) begin
                if (bin_mem[k] > peak) begin
                    peak = bin_mem[k];
                end
            end
            lvl     = level_from_peak(peak);
            decayed = (64'(bar_lvl[b]) * 64'(decay_q12)) >> 12;
            if (decayed > 4096) begin
                decayed = 4096;
            end
            if (64'(lvl) < decayed) begin
                lvl = LEVEL_W'(decayed);
            end
            bar_lvl[b] = lvl;
            res.idx    = IDX_W'(b);
            res.level  = lvl;
            res.last   = (b == BAR_COUNT - 1);
            bar_expect.push_back(res);
        end
        fill_cnt = 0;
    endtask

    function automatic bit send_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99, 0) < 66;
            IDLE_BOTH: return $urandom_range(99, 0) < 9;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_gap();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99, 0) < 66;
            IDLE_BOTH: return $urandom_range(99, 0) < 9;
            default:   return 1'b0;
        endcase
    endfunction

    // Spread magnitudes over all octaves, with full scale and the threshold region mixed in.
    function automatic logic [MAG_W-1:0] rand_magnitude();
        case ($urandom_range(9, 0))
            0:       return 32'hFFFF_FFFF;
            1:       return MAG_W'($urandom_range(20, 0));
            default: return $urandom >> $urandom_range(31, 0);
        endcase
    endfunction

    task automatic queue_bin(logic [MAG_W-1:0] mag, logic last);
        bin_word_t word;
        word.mag  = mag;
        word.last = last;
        bin_queue.push_back(word);
    endtask

    task automatic queue_frame(int len);
        for (int i = 0; i < len; i++) begin
            queue_bin(rand_magnitude(), i == len - 1);
        end
    endtask

    // Mostly short frames, now and then a longer one, until the item count is reached.
    task automatic queue_random_frames(int items);
        int placed;
        int len;
        placed = 0;
        while (placed < items) begin
            if ($urandom_range(9, 0) == 0) begin
                len = $urandom_range(200, 25);
            end else begin
                len = $urandom_range(24, 1);
            end
            queue_frame(len);
            placed += len;
        end
    endtask

    // Register write; called at a clock edge and returns at one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        if (idx == sblm_pkg::REG_DECAY) begin
            decay_q12 = data;
        end else if (idx == sblm_pkg::REG_FLOOR) begin
            floor_span = data[FLOOR_W-1:0];
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every bin is taken and every bar result is back, then let the block settle.
    task automatic drain();
        while (bin_queue.size() != 0 || bar_expect.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(idle_mode_t mode, logic [CFG_DATA_W-1:0] decay,
                             logic [CFG_DATA_W-1:0] span, int items);
        drain();
        write_reg(sblm_pkg::REG_DECAY, decay);
        write_reg(sblm_pkg::REG_FLOOR, span);
        idle_mode = mode;
        queue_random_frames(items);
    endtask

    // Input driver: hold the word until taken, then offer the next one unless idling.
    always @(posedge aclk) begin : bin_driver
        bin_word_t word;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                word = bin_queue.pop_front();
                predict_bars(word);
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (bin_queue.size() != 0 && !send_gap()) begin
                s_valid     <= 1'b1;
                s_magnitude <= bin_queue[0].mag;
                s_last_bin  <= bin_queue[0].last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off, started by the first bar result after reset.
    always @(posedge aclk) begin : hold_off_count
        if (!aresetn) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && m_valid) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare each taken bar word with the oldest expectation.
    always @(posedge aclk) begin : bar_monitor
        bar_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bar_expect.size() == 0) begin
                    $display("%0t: unexpected bar word, expected none, %s %0d level %0d",
                             $time, "actual index", m_bar_index, m_bar_level);
                    error_count++;
                end else begin
                    want = bar_expect.pop_front();
                    if (m_bar_index !== want.idx) begin
                        $display("%0t: bar_index expected %0d actual %0d",
                                 $time, want.idx, m_bar_index);
                        error_count++;
                    end
                    if (m_bar_level !== want.level) begin
                        $display("%0t: bar_level of bar %0d expected %0d actual %0d",
                                 $time, want.idx, want.level, m_bar_level);
                        error_count++;
                    end
                    if (m_last_bar !== want.last) begin
                        $display("%0t: last_bar of bar %0d expected %0d actual %0d",
                                 $time, want.idx, want.last, m_last_bar);
                        error_count++;
                    end
                end
            end
            m_ready <= (hold_left == 0) && !recv_gap();
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin : stimulus
        for (int b = 0; b < BAR_COUNT; b++) begin
            bar_lvl[b] = '0;
        end
        for (int i = 0; i <= BAR_COUNT; i++) begin
            edge_tab[i] = bar_edge(i);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values, no idling. The first frame fills every bin and runs past the end.
        idle_mode = IDLE_NONE;
        write_reg(sblm_pkg::REG_DECAY, sblm_pkg::DECAY_RESET);
        write_reg(sblm_pkg::REG_FLOOR, CFG_DATA_W'(sblm_pkg::FLOOR_RESET));
        queue_bin(32'h0000_0000, 1'b0);
        queue_bin(32'hFFFF_FFFF, 1'b0);
        queue_bin(sblm_pkg::THRESH_RAW, 1'b0);
        queue_bin(sblm_pkg::THRESH_RAW + 1, 1'b0);
        queue_bin(32'h0100_0000, 1'b0);
        for (int i = 5; i < BIN_COUNT + 6; i++) begin
            queue_bin(rand_magnitude(), i == BIN_COUNT + 5);
        end

        // Short frames that only rewrite the low bins: maximum, threshold, full scale, zero.
        queue_bin(32'hFFFF_FFFF, 1'b1);
        queue_bin(sblm_pkg::THRESH_RAW, 1'b0);
        queue_bin(sblm_pkg::THRESH_RAW + 1, 1'b1);
        queue_bin(32'h0000_0000, 1'b0);
        queue_bin(32'h0000_0000, 1'b0);
        queue_bin(32'h0000_0000, 1'b0);
        queue_bin(32'h0100_0000, 1'b1);
        queue_bin(32'h0000_0000, 1'b1);
        for (int i = 0; i < 8; i++) begin
            queue_bin(32'hFFFF_FFFF, i == 7);
        end
        queue_bin(32'h0000_0001, 1'b0);
        queue_bin(32'h8000_0000, 1'b1);

        // Settings from no decay to decay above one, and floor spans from zero to the top.
        run_phase(IDLE_SEND, 13'd0, 13'd1, 110);
        drain();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        run_phase(IDLE_RECV, 13'd8191, 13'd127, 110);
        run_phase(IDLE_BOTH, 13'd4096, 13'd0, 110);
        run_phase(IDLE_NONE, CFG_DATA_W'($urandom_range(4096, 1)),
                  CFG_DATA_W'($urandom_range(120, 1)), 30);
        drain();

        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
